@@ src/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define LPMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check on every clock edge, reset included
`define LPMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/lpmc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the point deskew unit
`timescale 1ns / 1ps
package lpmc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_W       = 20;
    localparam int COORD_W       = 32;
    localparam int TAG_W         = 24;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int SHARE_W       = FRAC_BITS + 1;
    localparam int TEN_W         = FRAC_BITS + 4;
    localparam int CW            = 32;
    localparam int A30_W         = 36;
    localparam int OP_W          = COORD_W + 1;
    localparam int TERM_W        = 35;
    localparam int ACC_W         = 37;
    localparam int Q30_SHIFT     = 30 - FRAC_BITS;

    localparam logic signed [A30_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [A30_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [A30_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [CW-1:0]    Q30_GAIN    = 32'sd652032874;
    localparam logic signed [CW-1:0]    Q30_ONE     = 32'sd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_X,
        REG_ANGLE_Y,
        REG_ANGLE_Z,
        REG_SHIFT_X,
        REG_SHIFT_Y,
        REG_SHIFT_Z
    } cfg_reg_t;

    typedef logic [2:0][CW-1:0] lane3_t;

    typedef struct packed {
        logic                       mode;
        logic [2:0]                 neg;
        logic [TAG_W-1:0]           tag;
        logic [2:0][OP_W-1:0]       op;
        logic [2:0][COORD_W-1:0]    shift;
    } lpmc_side_t;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        case (idx)
            0:  return 32'sd843314857;
            1:  return 32'sd497837829;
            2:  return 32'sd263043837;
            3:  return 32'sd133525159;
            4:  return 32'sd67021687;
            5:  return 32'sd33543516;
            6:  return 32'sd16775851;
            7:  return 32'sd8388437;
            8:  return 32'sd4194283;
            9:  return 32'sd2097149;
            10: return 32'sd1048576;
            11: return 32'sd524288;
            12: return 32'sd262144;
            13: return 32'sd131072;
            14: return 32'sd65536;
            15: return 32'sd32768;
            16: return 32'sd16384;
            17: return 32'sd8192;
            18: return 32'sd4096;
            19: return 32'sd2048;
            20: return 32'sd1024;
            21: return 32'sd512;
            22: return 32'sd256;
            23: return 32'sd128;
            default: return 32'sd0;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] sat_q30(input logic signed [CW+1:0] v);
        if (v > (CW+2)'(Q30_ONE)) begin
            return Q30_ONE;
        end else if (v < -(CW+2)'(Q30_ONE)) begin
            return -Q30_ONE;
        end
        return CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        return CW'(p >>> 30);
    endfunction

endpackage

@@ src/lidar_point_motion_compensation_unit.sv @@
// Lidar point deskew: shares frame motion by point time, rotates and shifts the point
// Throughput: one request per cycle while the output is not stalled;
// every stage, including the CORDIC cells, is pipelined.
// A stalled result holds the whole pipeline; s_ready follows m_ready or a free output.
// Reset clears all valid flags and the six motion registers to zero.
`timescale 1ns / 1ps
module lidar_point_motion_compensation_unit #(
    parameter int CORDIC_STAGES = lpmc_pkg::CORDIC_STAGES
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [lpmc_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [lpmc_pkg::CFG_W-1:0]            cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic signed [lpmc_pkg::COORD_W-1:0]   s_point_x,
    input  logic signed [lpmc_pkg::COORD_W-1:0]   s_point_y,
    input  logic signed [lpmc_pkg::COORD_W-1:0]   s_point_z,
    input  logic [lpmc_pkg::TAG_W-1:0]            s_point_tag,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [lpmc_pkg::COORD_W-1:0]   m_out_x,
    output logic signed [lpmc_pkg::COORD_W-1:0]   m_out_y,
    output logic signed [lpmc_pkg::COORD_W-1:0]   m_out_z,
    output logic [lpmc_pkg::TAG_W-1:0]            m_out_tag
);
    import lpmc_pkg::*;

    localparam logic [TEN_W-1:0] SHARE_ONE = TEN_W'(1) << FRAC_BITS;
    localparam logic [TEN_W-1:0] TEN       = TEN_W'(10);
    localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) << (COORD_W-1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -(ACC_W'(1) << (COORD_W-1));

    logic signed [ANGLE_W-1:0] angle_reg [3];
    logic signed [COORD_W-1:0] shift_cfg_reg [3];

    logic en;

    // stage 0
    logic [TEN_W-1:0]          frac10;
    logic [SHARE_W-1:0]        share_cap, share_next;
    logic                      v0_reg, mode0_reg;
    logic [SHARE_W-1:0]        share0_reg;
    logic signed [COORD_W-1:0] p0_reg [3];
    logic [TAG_W-1:0]          tag0_reg;

    // stage 1
    logic signed [ANGLE_W+SHARE_W:0] aprod [3];
    logic signed [COORD_W+SHARE_W:0] tprod [3];
    logic                      v1_reg, mode1_reg;
    logic signed [ANGLE_W-1:0] ang1_reg [3];
    logic signed [COORD_W-1:0] t1_reg [3];
    logic signed [COORD_W-1:0] p1_reg [3];
    logic [TAG_W-1:0]          tag1_reg;

    // stage 2
    logic signed [A30_W-1:0]   a30 [3];
    logic signed [A30_W-1:0]   aw [3];
    logic signed [A30_W-1:0]   af [3];
    lane3_t                    z2_next, z2_reg;
    lpmc_side_t                side2_next, side2_reg;
    logic                      v2_reg;

    // cell chain
    logic                      cv_w [CORDIC_STAGES+1];
    lane3_t                    cx_w [CORDIC_STAGES+1];
    lane3_t                    cy_w [CORDIC_STAGES+1];
    lane3_t                    cz_w [CORDIC_STAGES+1];
    lpmc_side_t                cs_w [CORDIC_STAGES+1];

    // stage 3
    logic signed [CW:0]        cneg [3];
    logic signed [CW:0]        sneg [3];
    logic signed [CW-1:0]      cos3_reg [3];
    logic signed [CW-1:0]      sin3_reg [3];
    lpmc_side_t                side3_reg;
    logic                      v3_reg;

    // stage 4
    logic signed [CW-1:0]      czcy4_reg, czsy4_reg, szcx4_reg, szsx4_reg, szcy4_reg;
    logic signed [CW-1:0]      szsy4_reg, czcx4_reg, czsx4_reg, cysx4_reg, cycx4_reg;
    logic signed [CW-1:0]      sx4_reg, cx4_reg, sy4_reg;
    lpmc_side_t                side4_reg;
    logic                      v4_reg;

    // stage 5
    logic signed [CW-1:0]      czsysx5_reg, czsycx5_reg, szsysx5_reg, szsycx5_reg;
    logic signed [CW-1:0]      czcy5_reg, szcx5_reg, szsx5_reg, szcy5_reg;
    logic signed [CW-1:0]      czcx5_reg, czsx5_reg, cysx5_reg, cycx5_reg, sy5_reg;
    lpmc_side_t                side5_reg;
    logic                      v5_reg;

    // stage 6
    logic signed [CW-1:0]      r6_next [9];
    logic signed [CW-1:0]      r6_reg [9];
    lpmc_side_t                side6_reg;
    logic                      v6_reg;

    // stage 7
    logic signed [CW-1:0]        coef [9];
    logic signed [OP_W-1:0]      opj [9];
    logic signed [CW+OP_W-1:0]   tp [9];
    logic signed [TERM_W-1:0]    term7_next [9];
    logic signed [TERM_W-1:0]    term7_reg [9];
    lpmc_side_t                  side7_reg;
    logic                        v7_reg;

    // stage 8
    logic signed [ACC_W-1:0]     acc [3];
    logic signed [COORD_W-1:0]   o_next [3];
    logic signed [COORD_W-1:0]   o_reg [3];
    logic [TAG_W-1:0]            tag8_reg;
    logic                        m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                angle_reg[k]     <= '0;
                shift_cfg_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ANGLE_X: angle_reg[0]     <= cfg_wr_data[ANGLE_W-1:0];
                REG_ANGLE_Y: angle_reg[1]     <= cfg_wr_data[ANGLE_W-1:0];
                REG_ANGLE_Z: angle_reg[2]     <= cfg_wr_data[ANGLE_W-1:0];
                REG_SHIFT_X: shift_cfg_reg[0] <= cfg_wr_data[COORD_W-1:0];
                REG_SHIFT_Y: shift_cfg_reg[1] <= cfg_wr_data[COORD_W-1:0];
                REG_SHIFT_Z: shift_cfg_reg[2] <= cfg_wr_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        frac10     = TEN_W'(s_point_tag[FRAC_BITS-1:0]) * TEN;
        share_cap  = (frac10 > SHARE_ONE) ? SHARE_ONE[SHARE_W-1:0] : frac10[SHARE_W-1:0];
        share_next = s_mode ? (SHARE_ONE[SHARE_W-1:0] - share_cap) : share_cap;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            aprod[k] = angle_reg[k] * $signed({1'b0, share0_reg});
            tprod[k] = shift_cfg_reg[k] * $signed({1'b0, share0_reg});
        end
    end

    always_comb begin
        side2_next.mode = mode1_reg;
        side2_next.tag  = tag1_reg;
        for (int k = 0; k < 3; k++) begin
            a30[k] = A30_W'(ang1_reg[k]) <<< Q30_SHIFT;
            if (a30[k] > Q30_PI) begin
                aw[k] = a30[k] - Q30_TWO_PI;
            end else if (a30[k] < -Q30_PI) begin
                aw[k] = a30[k] + Q30_TWO_PI;
            end else begin
                aw[k] = a30[k];
            end
            if (aw[k] > Q30_HALF_PI) begin
                af[k]             = aw[k] - Q30_PI;
                side2_next.neg[k] = 1'b1;
            end else if (aw[k] < -Q30_HALF_PI) begin
                af[k]             = aw[k] + Q30_PI;
                side2_next.neg[k] = 1'b1;
            end else begin
                af[k]             = aw[k];
                side2_next.neg[k] = 1'b0;
            end
            z2_next[k]          = af[k][CW-1:0];
            side2_next.shift[k] = t1_reg[k];
            side2_next.op[k]    = mode1_reg ? OP_W'(p1_reg[k])
                                            : OP_W'(p1_reg[k]) - OP_W'(t1_reg[k]);
        end
    end

    assign cv_w[0] = v2_reg;
    assign cx_w[0] = {Q30_GAIN, Q30_GAIN, Q30_GAIN};
    assign cy_w[0] = '0;
    assign cz_w[0] = z2_reg;
    assign cs_w[0] = side2_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        lpmc_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (cv_w[g]),
            .in_x     (cx_w[g]),
            .in_y     (cy_w[g]),
            .in_z     (cz_w[g]),
            .in_side  (cs_w[g]),
            .out_valid(cv_w[g+1]),
            .out_x    (cx_w[g+1]),
            .out_y    (cy_w[g+1]),
            .out_z    (cz_w[g+1]),
            .out_side (cs_w[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cneg[k] = cs_w[CORDIC_STAGES].neg[k] ? -(CW+1)'($signed(cx_w[CORDIC_STAGES][k]))
                                                 : (CW+1)'($signed(cx_w[CORDIC_STAGES][k]));
            sneg[k] = cs_w[CORDIC_STAGES].neg[k] ? -(CW+1)'($signed(cy_w[CORDIC_STAGES][k]))
                                                 : (CW+1)'($signed(cy_w[CORDIC_STAGES][k]));
        end
    end

    always_comb begin
        r6_next[0] = sat_q30((CW+2)'(czcy5_reg));
        r6_next[1] = sat_q30((CW+2)'(czsysx5_reg) - (CW+2)'(szcx5_reg));
        r6_next[2] = sat_q30((CW+2)'(czsycx5_reg) + (CW+2)'(szsx5_reg));
        r6_next[3] = sat_q30((CW+2)'(szcy5_reg));
        r6_next[4] = sat_q30((CW+2)'(szsysx5_reg) + (CW+2)'(czcx5_reg));
        r6_next[5] = sat_q30((CW+2)'(szsycx5_reg) - (CW+2)'(czsx5_reg));
        r6_next[6] = sat_q30(-(CW+2)'(sy5_reg));
        r6_next[7] = sat_q30((CW+2)'(cysx5_reg));
        r6_next[8] = sat_q30((CW+2)'(cycx5_reg));
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef[i*3+j]       = side6_reg.mode ? r6_reg[i*3+j] : r6_reg[j*3+i];
                opj[i*3+j]        = $signed(side6_reg.op[j]);
                tp[i*3+j]         = coef[i*3+j] * opj[i*3+j];
                term7_next[i*3+j] = TERM_W'(tp[i*3+j] >>> 30);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = ACC_W'(term7_reg[i*3]) + ACC_W'(term7_reg[i*3+1])
                   + ACC_W'(term7_reg[i*3+2])
                   + (side7_reg.mode ? ACC_W'($signed(side7_reg.shift[i])) : ACC_W'(0));
            if (acc[i] > OUT_MAX) begin
                o_next[i] = OUT_MAX[COORD_W-1:0];
            end else if (acc[i] < OUT_MIN) begin
                o_next[i] = OUT_MIN[COORD_W-1:0];
            end else begin
                o_next[i] = acc[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= s_valid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= cv_w[CORDIC_STAGES];
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            m_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode0_reg  <= s_mode;
            share0_reg <= share_next;
            p0_reg[0]  <= s_point_x;
            p0_reg[1]  <= s_point_y;
            p0_reg[2]  <= s_point_z;
            tag0_reg   <= s_point_tag;

            mode1_reg <= mode0_reg;
            tag1_reg  <= tag0_reg;
            for (int k = 0; k < 3; k++) begin
                ang1_reg[k] <= ANGLE_W'(aprod[k] >>> FRAC_BITS);
                t1_reg[k]   <= COORD_W'(tprod[k] >>> FRAC_BITS);
                p1_reg[k]   <= p0_reg[k];
            end

            z2_reg    <= z2_next;
            side2_reg <= side2_next;

            for (int k = 0; k < 3; k++) begin
                cos3_reg[k] <= sat_q30((CW+2)'(cneg[k]));
                sin3_reg[k] <= sat_q30((CW+2)'(sneg[k]));
            end
            side3_reg <= cs_w[CORDIC_STAGES];

            czcy4_reg <= mul30(cos3_reg[2], cos3_reg[1]);
            czsy4_reg <= mul30(cos3_reg[2], sin3_reg[1]);
            szcx4_reg <= mul30(sin3_reg[2], cos3_reg[0]);
            szsx4_reg <= mul30(sin3_reg[2], sin3_reg[0]);
            szcy4_reg <= mul30(sin3_reg[2], cos3_reg[1]);
            szsy4_reg <= mul30(sin3_reg[2], sin3_reg[1]);
            czcx4_reg <= mul30(cos3_reg[2], cos3_reg[0]);
            czsx4_reg <= mul30(cos3_reg[2], sin3_reg[0]);
            cysx4_reg <= mul30(cos3_reg[1], sin3_reg[0]);
            cycx4_reg <= mul30(cos3_reg[1], cos3_reg[0]);
            sx4_reg   <= sin3_reg[0];
            cx4_reg   <= cos3_reg[0];
            sy4_reg   <= sin3_reg[1];
            side4_reg <= side3_reg;

            czsysx5_reg <= mul30(czsy4_reg, sx4_reg);
            czsycx5_reg <= mul30(czsy4_reg, cx4_reg);
            szsysx5_reg <= mul30(szsy4_reg, sx4_reg);
            szsycx5_reg <= mul30(szsy4_reg, cx4_reg);
            czcy5_reg   <= czcy4_reg;
            szcx5_reg   <= szcx4_reg;
            szsx5_reg   <= szsx4_reg;
            szcy5_reg   <= szcy4_reg;
            czcx5_reg   <= czcx4_reg;
            czsx5_reg   <= czsx4_reg;
            cysx5_reg   <= cysx4_reg;
            cycx5_reg   <= cycx4_reg;
            sy5_reg     <= sy4_reg;
            side5_reg   <= side4_reg;

            r6_reg    <= r6_next;
            side6_reg <= side5_reg;

            term7_reg <= term7_next;
            side7_reg <= side6_reg;

            o_reg    <= o_next;
            tag8_reg <= side7_reg.tag;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_x   = o_reg[0];
    assign m_out_y   = o_reg[1];
    assign m_out_z   = o_reg[2];
    assign m_out_tag = tag8_reg;

endmodule

@@ src/lpmc_cordic_cell.sv @@
// One CORDIC rotation cell for the three angle lanes
`timescale 1ns / 1ps
module lpmc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  lpmc_pkg::lane3_t   in_x,
    input  lpmc_pkg::lane3_t   in_y,
    input  lpmc_pkg::lane3_t   in_z,
    input  lpmc_pkg::lpmc_side_t in_side,
    output logic               out_valid,
    output lpmc_pkg::lane3_t   out_x,
    output lpmc_pkg::lane3_t   out_y,
    output lpmc_pkg::lane3_t   out_z,
    output lpmc_pkg::lpmc_side_t out_side
);
    import lpmc_pkg::*;

    localparam logic signed [CW-1:0] ATAN = atan_q30(STAGE);

    logic       valid_reg;
    lane3_t     x_reg, y_reg, z_reg;
    lane3_t     x_next, y_next, z_next;
    lpmc_side_t side_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!in_z[k][CW-1]) begin
                x_next[k] = in_x[k] - CW'($signed(in_y[k]) >>> STAGE);
                y_next[k] = in_y[k] + CW'($signed(in_x[k]) >>> STAGE);
                z_next[k] = in_z[k] - ATAN;
            end else begin
                x_next[k] = in_x[k] + CW'($signed(in_y[k]) >>> STAGE);
                y_next[k] = in_y[k] - CW'($signed(in_x[k]) >>> STAGE);
                z_next[k] = in_z[k] + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

@@ src/lpmc_checker.sv @@
// Port-level checker for the point deskew unit, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lpmc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [lpmc_pkg::COORD_W-1:0] m_out_x,
    input logic signed [lpmc_pkg::COORD_W-1:0] m_out_y,
    input logic signed [lpmc_pkg::COORD_W-1:0] m_out_z,
    input logic [lpmc_pkg::TAG_W-1:0]          m_out_tag
);
    `LPMC_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `LPMC_ASSERT(a_ready_when_free, !m_valid |-> s_ready, "request refused with free output")
    `LPMC_ASSERT(a_stall_blocks, (m_valid && !m_ready) |-> !s_ready, "request taken during stall")
    `LPMC_ASSERT(a_result_holds, (m_valid && !m_ready) |=> (m_valid && $stable(m_out_x) && $stable(m_out_y) && $stable(m_out_z) && $stable(m_out_tag)), "stalled result changed")
endmodule

bind lidar_point_motion_compensation_unit lpmc_checker u_lpmc_checker (.*);
